@@ rtl/vwu_pkg.sv @@
// ---------------------------------------------------------------------------
// vwu_pkg - shared types and constants for the vertex weld unique index block
// Word formats, register indexes, attribute codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package vwu_pkg;

    // Table geometry default and field counts
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VWU_FIELDS      = 10;
    localparam int FIELD_W         = 64;
    localparam int EPS_W           = 31;
    localparam int ATTR_W          = 3;
    localparam int OUT_IDX_W       = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_ATTR = 1'b1;

    // Tolerant attribute codes (others mean exact)
    localparam logic [ATTR_W-1:0] ATTR_NONE      = 3'd0;
    localparam logic [ATTR_W-1:0] ATTR_POSITION  = 3'd1;
    localparam logic [ATTR_W-1:0] ATTR_NORMAL    = 3'd2;
    localparam logic [ATTR_W-1:0] ATTR_TEXCOORD  = 3'd3;
    localparam logic [ATTR_W-1:0] ATTR_TANGENT   = 3'd4;
    localparam logic [ATTR_W-1:0] ATTR_BITANGENT = 3'd5;

    // One stored vertex: ten fields, position_xy at the top
    typedef struct packed {
        logic [FIELD_W-1:0] position_xy;
        logic [FIELD_W-1:0] position_zw;
        logic [FIELD_W-1:0] normal_xy;
        logic [FIELD_W-1:0] normal_zw;
        logic [FIELD_W-1:0] texcoord_xy;
        logic [FIELD_W-1:0] texcoord_zw;
        logic [FIELD_W-1:0] tangent_xy;
        logic [FIELD_W-1:0] tangent_zw;
        logic [FIELD_W-1:0] bitangent_xy;
        logic [FIELD_W-1:0] bitangent_zw;
    } vwu_vertex_t;

    // Input word
    typedef struct packed {
        logic               clear_table;
        logic [FIELD_W-1:0] position_xy;
        logic [FIELD_W-1:0] position_zw;
        logic [FIELD_W-1:0] normal_xy;
        logic [FIELD_W-1:0] normal_zw;
        logic [FIELD_W-1:0] texcoord_xy;
        logic [FIELD_W-1:0] texcoord_zw;
        logic [FIELD_W-1:0] tangent_xy;
        logic [FIELD_W-1:0] tangent_zw;
        logic [FIELD_W-1:0] bitangent_xy;
        logic [FIELD_W-1:0] bitangent_zw;
    } vwu_in_t;

    // Result word
    typedef struct packed {
        logic [OUT_IDX_W-1:0] unique_index;
        logic                 newly_added;
        logic                 table_overflow;
    } vwu_out_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } vwu_state_t;

endpackage

`default_nettype wire

@@ rtl/vertex_weld_unique_index.sv @@
// ---------------------------------------------------------------------------
// vertex_weld_unique_index - vertex welding into a table of unique vertices
// Looks each vertex up in entry order, returns the first matching index or
// appends it; one attribute may be compared within an epsilon.
//
//   channel | ports                          | word
//   --------+--------------------------------+------------------------------
//   input   | s_valid s_ready s_word         | clear flag + ten 64-bit fields
//   result  | m_valid m_ready m_word         | index, new flag, overflow flag
//   config  | cfg_we cfg_index cfg_data      | epsilon, tolerant attribute
//
// A vertex's result is registered once the walk over the stored entries ends
// (no walk when the table is empty or the vertex clears it): the table read
// port delivers one entry per cycle to the single compare unit. A hit ends
// the walk early. The next vertex is taken only once the sequencer is back in
// idle after the result is registered, so one vertex is in flight at a time.
// Reset (aresetn low, synchronous) empties the table; no clearing pass.
// A finished result waits in the output register; the next vertex is taken
// meanwhile, and its result is held back while m_ready stays low.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_weld_unique_index #(
    parameter int TABLE_DEPTH = vwu_pkg::TABLE_DEPTH_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  vwu_pkg::vwu_in_t                  s_word,
    output logic                              m_valid,
    input  wire                               m_ready,
    output vwu_pkg::vwu_out_t                 m_word,
    input  wire                               cfg_we,
    input  wire [vwu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [vwu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OW    = vwu_pkg::OUT_IDX_W;

    vwu_pkg::vwu_state_t  state_reg;
    vwu_pkg::vwu_state_t  state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic [IDX_W-1:0]     scan_reg;
    logic                 vld_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     found_reg;
    vwu_pkg::vwu_vertex_t vertex_reg;
    vwu_pkg::vwu_out_t    out_reg;
    logic                 m_valid_reg;
    logic [vwu_pkg::EPS_W-1:0]  eps_reg;
    logic [vwu_pkg::ATTR_W-1:0] attr_reg;

    vwu_pkg::vwu_vertex_t rd_data;
    logic                 match;
    logic                 s_fire;
    logic                 last;
    logic                 scan_stop;
    logic                 finish_go;
    logic                 room;
    logic                 wr_en;
    logic [IDX_W+OW-1:0]  found_wide;
    logic [CNT_W+OW-1:0]  count_wide;

    // Table and compare unit
    vwu_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (vertex_reg),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    vwu_match u_match (
        .stored   (rd_data),
        .vertex   (vertex_reg),
        .epsilon  (eps_reg),
        .tol_attr (attr_reg),
        .match    (match)
    );

    assign s_fire     = s_valid && s_ready;
    assign last       = ({{(CNT_W-IDX_W){1'b0}}, scan_reg} == (count_reg - CNT_W'(1)));
    assign scan_stop  = vld_reg && (match || last);
    assign room       = (count_reg < CNT_W'(TABLE_DEPTH));
    assign found_wide = {{OW{1'b0}}, found_reg};
    assign count_wide = {{OW{1'b0}}, count_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vwu_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_word.clear_table || (count_reg == '0)) begin
                        state_next = vwu_pkg::ST_FINISH;
                    end else begin
                        state_next = vwu_pkg::ST_SEARCH;
                    end
                end
            end
            vwu_pkg::ST_SEARCH: begin
                if (scan_stop) begin
                    state_next = vwu_pkg::ST_FINISH;
                end
            end
            vwu_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = vwu_pkg::ST_IDLE;
                end
            end
            default: state_next = vwu_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = (state_reg == vwu_pkg::ST_IDLE);
        finish_go = (state_reg == vwu_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
        wr_en     = finish_go && !hit_reg && room;
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vwu_pkg::ST_IDLE;
            count_reg   <= '0;
            addr_reg    <= '0;
            scan_reg    <= '0;
            vld_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Latch a new vertex, drop the table on clear
            if (s_fire) begin
                addr_reg <= '0;
                vld_reg  <= 1'b0;
                hit_reg  <= 1'b0;
                if (s_word.clear_table) begin
                    count_reg <= '0;
                end
            end

            // Walk the table: issue one read, check the previous one
            if (state_reg == vwu_pkg::ST_SEARCH) begin
                if (vld_reg && match) begin
                    hit_reg <= 1'b1;
                end else if (!scan_stop) begin
                    vld_reg  <= 1'b1;
                    scan_reg <= addr_reg;
                    addr_reg <= addr_reg + IDX_W'(1);
                end
            end

            // Append on a miss with room left
            if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // Output register handshake
            if (finish_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            vertex_reg.position_xy  <= s_word.position_xy;
            vertex_reg.position_zw  <= s_word.position_zw;
            vertex_reg.normal_xy    <= s_word.normal_xy;
            vertex_reg.normal_zw    <= s_word.normal_zw;
            vertex_reg.texcoord_xy  <= s_word.texcoord_xy;
            vertex_reg.texcoord_zw  <= s_word.texcoord_zw;
            vertex_reg.tangent_xy   <= s_word.tangent_xy;
            vertex_reg.tangent_zw   <= s_word.tangent_zw;
            vertex_reg.bitangent_xy <= s_word.bitangent_xy;
            vertex_reg.bitangent_zw <= s_word.bitangent_zw;
        end
        if ((state_reg == vwu_pkg::ST_SEARCH) && vld_reg && match) begin
            found_reg <= scan_reg;
        end
        if (finish_go) begin
            priority if (hit_reg) begin
                out_reg.unique_index   <= found_wide[OW-1:0];
                out_reg.newly_added    <= 1'b0;
                out_reg.table_overflow <= 1'b0;
            end else if (room) begin
                out_reg.unique_index   <= count_wide[OW-1:0];
                out_reg.newly_added    <= 1'b1;
                out_reg.table_overflow <= 1'b0;
            end else begin
                out_reg.unique_index   <= '0;
                out_reg.newly_added    <= 1'b0;
                out_reg.table_overflow <= 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg  <= '0;
            attr_reg <= vwu_pkg::ATTR_NONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vwu_pkg::CFG_EPSILON:  eps_reg  <= cfg_data;
                vwu_pkg::CFG_TOL_ATTR: attr_reg <= cfg_data[vwu_pkg::ATTR_W-1:0];
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

    // Checks
    a_search_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vwu_pkg::ST_SEARCH) |-> (count_reg != '0))
        else $error("search started on an empty table");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == vwu_pkg::ST_SEARCH) && vld_reg) |->
            ({{(CNT_W-IDX_W){1'b0}}, scan_reg} < count_reg))
        else $error("compared an entry that was never written");

    a_overflow_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.table_overflow) |->
            ((m_word.unique_index == '0) && !m_word.newly_added))
        else $error("overflow result carries an index");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("second vertex taken while one is in flight");

endmodule

`default_nettype wire

@@ rtl/vwu_store.sv @@
// ---------------------------------------------------------------------------
// vwu_store - unique vertex table
// One write port, one read port with registered read data, one vertex a row.
// ---------------------------------------------------------------------------
`default_nettype none

module vwu_store #(
    parameter int DEPTH  = vwu_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  vwu_pkg::vwu_vertex_t wr_data,
    input  wire [ADDR_W-1:0]     rd_addr,
    output vwu_pkg::vwu_vertex_t rd_data
);

    vwu_pkg::vwu_vertex_t mem [DEPTH];

    // Write one row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one row, registered
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/vwu_match.sv @@
// ---------------------------------------------------------------------------
// vwu_match - entry compare unit
// Compares one stored vertex against the held vertex: exact on all fields,
// except the four words of the tolerant attribute, checked by |a - b| <= eps.
// ---------------------------------------------------------------------------
`default_nettype none

module vwu_match (
    input  vwu_pkg::vwu_vertex_t             stored,
    input  vwu_pkg::vwu_vertex_t             vertex,
    input  wire [vwu_pkg::EPS_W-1:0]         epsilon,
    input  wire [vwu_pkg::ATTR_W-1:0]        tol_attr,
    output logic                             match
);

    localparam int NF = vwu_pkg::VWU_FIELDS;

    logic [NF-1:0][vwu_pkg::FIELD_W-1:0] sf;
    logic [NF-1:0][vwu_pkg::FIELD_W-1:0] vf;
    logic          tol_on;
    logic [2:0]    pair;
    logic [3:0]    fa;
    logic [3:0]    fb;
    logic [NF-1:0] field_ok;
    logic          tol_ok;

    // Signed Q16.16 distance check, exact in 33 bits
    function automatic logic word_close(input logic [31:0] a,
                                        input logic [31:0] b,
                                        input logic [vwu_pkg::EPS_W-1:0] eps);
        logic [32:0] d;
        logic [32:0] mag;
        d   = {a[31], a} - {b[31], b};
        mag = d[32] ? (~d + 33'd1) : d;
        return mag <= {2'b00, eps};
    endfunction

    assign sf = stored;
    assign vf = vertex;

    // Decode the tolerant attribute into a field pair
    always_comb begin
        tol_on = 1'b1;
        pair   = 3'd0;
        unique case (tol_attr)
            vwu_pkg::ATTR_POSITION:  pair = 3'd0;
            vwu_pkg::ATTR_NORMAL:    pair = 3'd1;
            vwu_pkg::ATTR_TEXCOORD:  pair = 3'd2;
            vwu_pkg::ATTR_TANGENT:   pair = 3'd3;
            vwu_pkg::ATTR_BITANGENT: pair = 3'd4;
            default:                 tol_on = 1'b0;
        endcase
    end

    // Field k of the list sits at packed index NF-1-k
    assign fa = 4'(NF - 1) - {pair, 1'b0};
    assign fb = fa - 4'd1;

    // Each tolerant word through its own distance check
    assign tol_ok = !tol_on ||
        (word_close(sf[fa][31:0],  vf[fa][31:0],  epsilon) &&
         word_close(sf[fa][63:32], vf[fa][63:32], epsilon) &&
         word_close(sf[fb][31:0],  vf[fb][31:0],  epsilon) &&
         word_close(sf[fb][63:32], vf[fb][63:32], epsilon));

    // Exact compare on every field outside the tolerant pair
    always_comb begin
        for (int k = 0; k < NF; k++) begin
            field_ok[NF-1-k] = (tol_on && (3'(k / 2) == pair)) ||
                               (sf[NF-1-k] == vf[NF-1-k]);
        end
    end

    assign match = (&field_ok) && tol_ok;

endmodule

`default_nettype wire
